@@ rtl/core/lcg_rw_pkg.sv @@
package lcg_rw_pkg;

    // Field widths
    localparam int POS_W   = 14;
    localparam int MAG_W   = 13;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int P4_W    = 2 * SQ_W;
    localparam int SSQ_W   = 37;
    localparam int SP4_W   = 62;
    localparam int WORD_W  = 61;
    localparam int START_W = 12;
    localparam int CFG_W   = WORD_W;

    // Stream data widths, rounded up to whole bytes
    localparam int S_DATA_W = 8;
    localparam int M_DATA_RAW_W = POS_W + SSQ_W + SP4_W + WORD_W;
    localparam int M_DATA_W = ((M_DATA_RAW_W + 7) / 8) * 8;

    // Walk limits
    localparam int POS_BASE_LIMIT = 1024;
    localparam int DEFAULT_MAX_WALK_STEPS = 4096;

    // Generator constants
    localparam logic [63:0] LCG_MUL  = 64'd3125;
    localparam logic [63:0] LCG_INC  = 64'd16807;
    localparam logic [63:0] LCG_MOD  = 64'd1944674407370955169;
    localparam logic [WORD_W-1:0] SEED_RESET = WORD_W'(1);
    localparam int LCG_QMAX  = 9;
    localparam int LCG_TOP_W = 7;
    localparam int LCG_TOP_LSB = 64 - LCG_TOP_W;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_START_POSITION = 1'b0,
        CFG_INITIAL_SEED   = 1'b1
    } cfg_idx_t;

    // One step on its way from the input stage to the statistics pipeline
    typedef struct packed {
        logic                     first;
        logic signed [POS_W-1:0]  pos;
        logic [WORD_W-1:0]        word;
    } step_t;

    // Lower estimate of the quotient of a 64-bit value by the modulus,
    // taken from its top bits; the true quotient is this or one more
    function automatic logic [3:0] lcg_qest(input logic [LCG_TOP_W-1:0] top);
        logic [3:0]  q;
        logic [63:0] thr;
        q = 4'd0;
        for (int k = 1; k <= LCG_QMAX; k++) begin
            thr = (64'(k) * LCG_MOD + ((64'd1 << LCG_TOP_LSB) - 64'd1)) >> LCG_TOP_LSB;
            if (64'(top) >= thr) begin
                q = q + 4'd1;
            end
        end
        return q;
    endfunction

    // Multiple of the modulus for a small quotient
    function automatic logic [63:0] lcg_mod_mult(input logic [3:0] q);
        logic [63:0] res;
        res = 64'd0;
        for (int k = 1; k <= LCG_QMAX; k++) begin
            if (q == 4'(k)) begin
                res = LCG_MOD * 64'(k);
            end
        end
        return res;
    endfunction

endpackage

@@ rtl/core/lcg_rw_lcg.sv @@
module lcg_rw_lcg
    import lcg_rw_pkg::*;
(
    input  logic [WORD_W-1:0] state_i,
    output logic [WORD_W-1:0] next_o
);

    logic [63:0] s64;
    logic [63:0] prod;
    logic [3:0]  q;
    logic [63:0] rem0;
    logic [63:0] rem1;

    // Multiply by 3125 (shift-add), add the increment, wrap at 2^64
    assign s64  = 64'(state_i);
    assign prod = (s64 << 11) + (s64 << 10) + (s64 << 5) + (s64 << 4)
                + (s64 << 2) + s64 + LCG_INC;

    // Reduce by the modulus: estimate from the top bits, then one correction
    assign q    = lcg_qest(prod[63:LCG_TOP_LSB]);
    assign rem0 = prod - lcg_mod_mult(q);

    always_comb begin
        if (rem0 >= LCG_MOD) begin
            rem1 = rem0 - LCG_MOD;
        end else begin
            rem1 = rem0;
        end
    end

    assign next_o = rem1[WORD_W-1:0];

endmodule

@@ rtl/core/lcg_rw_stats.sv @@
module lcg_rw_stats
    import lcg_rw_pkg::*;
#(
    parameter int MAX_WALK_STEPS = DEFAULT_MAX_WALK_STEPS
)
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  step_t               in_step,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata
);

    localparam int          LIM    = POS_BASE_LIMIT + MAX_WALK_STEPS;
    localparam logic [63:0] CAP_SQ = 64'(MAX_WALK_STEPS) * 64'(LIM) * 64'(LIM);
    localparam logic [63:0] CAP_P4 = CAP_SQ * 64'(LIM) * 64'(LIM);
    localparam logic [SSQ_W-1:0] CAP_SQ_W = CAP_SQ[SSQ_W-1:0];
    localparam logic [SP4_W-1:0] CAP_P4_W = CAP_P4[SP4_W-1:0];

    // Square stage
    logic                    v2_reg;
    logic                    first2_reg;
    logic signed [POS_W-1:0] pos2_reg;
    logic [WORD_W-1:0]       word2_reg;
    logic [SQ_W-1:0]         sq2_reg;

    // Fourth power stage
    logic                    v3_reg;
    logic                    first3_reg;
    logic signed [POS_W-1:0] pos3_reg;
    logic [WORD_W-1:0]       word3_reg;
    logic [SQ_W-1:0]         sq3_reg;
    logic [P4_W-1:0]         p4_3_reg;

    // Result stage; the sums double as the result fields
    logic                    vout_reg;
    logic signed [POS_W-1:0] pos_out_reg;
    logic [WORD_W-1:0]       word_out_reg;
    logic [SSQ_W-1:0]        acc_sq_reg;
    logic [SSQ_W-1:0]        acc_sq_next;
    logic [SP4_W-1:0]        acc_p4_reg;
    logic [SP4_W-1:0]        acc_p4_next;

    logic                    ready_out;
    logic                    ready3;
    logic                    take2;
    logic                    take3;
    logic                    take_out;
    logic [POS_W-1:0]        abs_pos;
    logic [MAG_W-1:0]        mag;
    logic [SSQ_W-1:0]        base_sq;
    logic [SP4_W-1:0]        base_p4;
    logic [SSQ_W-1:0]        add_sq;
    logic [SP4_W-1:0]        add_p4;

    // Per-stage flow control: a stage takes a request when it is empty or drains
    assign ready_out = !vout_reg || m_tready;
    assign ready3    = !v3_reg || ready_out;
    assign in_ready  = !v2_reg || ready3;
    assign take2     = in_valid && in_ready;
    assign take3     = v2_reg && ready3;
    assign take_out  = v3_reg && ready_out;

    // Magnitude of the position
    assign abs_pos = in_step.pos[POS_W-1] ? POS_W'(-in_step.pos) : POS_W'(in_step.pos);
    assign mag     = abs_pos[MAG_W-1:0];

    // Saturating sums, cleared at the start of a walk
    always_comb begin
        base_sq = first3_reg ? '0 : acc_sq_reg;
        base_p4 = first3_reg ? '0 : acc_p4_reg;
        add_sq  = SSQ_W'(sq3_reg);
        add_p4  = SP4_W'(p4_3_reg);
        if (base_sq >= CAP_SQ_W || add_sq >= CAP_SQ_W - base_sq) begin
            acc_sq_next = CAP_SQ_W;
        end else begin
            acc_sq_next = base_sq + add_sq;
        end
        if (base_p4 >= CAP_P4_W || add_p4 >= CAP_P4_W - base_p4) begin
            acc_p4_next = CAP_P4_W;
        end else begin
            acc_p4_next = base_p4 + add_p4;
        end
    end

    // Valid bits and accumulators
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg     <= 1'b0;
            v3_reg     <= 1'b0;
            vout_reg   <= 1'b0;
            acc_sq_reg <= '0;
            acc_p4_reg <= '0;
        end else begin
            if (in_ready) begin
                v2_reg <= in_valid;
            end
            if (ready3) begin
                v3_reg <= v2_reg;
            end
            if (ready_out) begin
                vout_reg <= v3_reg;
            end
            if (take_out) begin
                acc_sq_reg <= acc_sq_next;
                acc_p4_reg <= acc_p4_next;
            end
        end
    end

    // Payload: square, then fourth power, then hold for the result
    always_ff @(posedge aclk) begin
        if (take2) begin
            first2_reg <= in_step.first;
            pos2_reg   <= in_step.pos;
            word2_reg  <= in_step.word;
            sq2_reg    <= SQ_W'(mag) * SQ_W'(mag);
        end
        if (take3) begin
            first3_reg <= first2_reg;
            pos3_reg   <= pos2_reg;
            word3_reg  <= word2_reg;
            sq3_reg    <= sq2_reg;
            p4_3_reg   <= P4_W'(sq2_reg) * P4_W'(sq2_reg);
        end
        if (take_out) begin
            pos_out_reg  <= pos3_reg;
            word_out_reg <= word3_reg;
        end
    end

    assign m_tvalid = vout_reg;
    assign m_tdata  = {(M_DATA_W - M_DATA_RAW_W)'(0), word_out_reg, acc_p4_reg,
                       acc_sq_reg, pos_out_reg};

endmodule

@@ rtl/core/lcg_random_walk_1d_top.sv @@
// Channel   | Ports                         | Request contents (lowest bit first)
// ----------+-------------------------------+----------------------------------------
// step in   | s_tvalid s_tready s_tdata[7:0]| [0] first_step, [7:1] unused
// result    | m_tvalid m_tready m_tdata     | [13:0] position, [50:14] sum_squares,
//           |   [175:0]                     | [112:51] sum_fourth_powers,
//           |                               | [173:113] random_word, [175:174] zero
// config    | cfg_we cfg_addr cfg_wdata     | 0 start_position, 1 initial_seed
//
// One step is taken per clock unless the result stalls; each stage registers the step.
// The clock is set by the generator loop: multiply by 3125 and one modular reduction.
// Squares and fourth powers go through two multiplier stages, sums at the result stage.
// Reset (aresetn low, synchronous) loads seed 1, start position 0, position 0, zero sums.
// A stalled result holds in its register while up to three more steps are taken.
module lcg_random_walk_1d_top
    import lcg_rw_pkg::*;
#(
    parameter int MAX_WALK_STEPS = DEFAULT_MAX_WALK_STEPS
)
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // [0] first_step
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // position, sum_squares, sum_fourth_powers,
                                           // random_word, zero fill
    input  logic                cfg_we,
    input  logic [0:0]          cfg_addr,
    input  logic [CFG_W-1:0]    cfg_wdata
);

    localparam int                  LIM    = POS_BASE_LIMIT + MAX_WALK_STEPS;
    localparam logic signed [POS_W-1:0] POS_HI = POS_W'(LIM);
    localparam logic signed [POS_W-1:0] POS_LO = POS_W'(-LIM);

    logic signed [START_W-1:0] start_pos_reg;
    logic [WORD_W-1:0]         gen_reg;
    logic [WORD_W-1:0]         gen_next;
    logic signed [POS_W-1:0]   pos_reg;
    logic signed [POS_W-1:0]   pos_base;
    logic signed [POS_W-1:0]   pos_next;
    logic                      v1_reg;
    step_t                     st1_reg;
    logic                      st_ready;
    logic                      accept;
    logic                      first_step;

    assign first_step = s_tdata[0];
    assign s_tready   = !v1_reg || st_ready;
    assign accept     = s_tvalid && s_tready;

    // Advance the generator
    lcg_rw_lcg u_lcg (
        .state_i (gen_reg),
        .next_o  (gen_next)
    );

    // Restart or continue the walk, then step by the parity of the new word
    always_comb begin
        pos_base = first_step ? POS_W'(start_pos_reg) : pos_reg;
        pos_next = pos_base;
        if (!gen_next[0]) begin
            if (pos_base < POS_HI) begin
                pos_next = pos_base + POS_W'(1);
            end
        end else begin
            if (pos_base > POS_LO) begin
                pos_next = pos_base - POS_W'(1);
            end
        end
    end

    // Walk state, configuration and input stage valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_pos_reg <= '0;
            gen_reg       <= SEED_RESET;
            pos_reg       <= '0;
            v1_reg        <= 1'b0;
        end else begin
            if (s_tready) begin
                v1_reg <= s_tvalid;
            end
            if (accept) begin
                gen_reg <= gen_next;
                pos_reg <= pos_next;
            end
            if (cfg_we) begin
                unique case (cfg_idx_t'(cfg_addr))
                    CFG_START_POSITION: start_pos_reg <= cfg_wdata[START_W-1:0];
                    CFG_INITIAL_SEED:   gen_reg       <= cfg_wdata[WORD_W-1:0];
                endcase
            end
        end
    end

    // Hand the step to the statistics pipeline
    always_ff @(posedge aclk) begin
        if (accept) begin
            st1_reg.first <= first_step;
            st1_reg.pos   <= pos_next;
            st1_reg.word  <= gen_next;
        end
    end

    lcg_rw_stats #(
        .MAX_WALK_STEPS (MAX_WALK_STEPS)
    ) u_stats (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (v1_reg),
        .in_ready (st_ready),
        .in_step  (st1_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

@@ test/lcg_random_walk_1d_top_tb.sv @@
module lcg_random_walk_1d_top_tb
    import lcg_rw_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Walk limits and saturation caps for the default step count
    localparam int WALK_LIMIT = POS_BASE_LIMIT + DEFAULT_MAX_WALK_STEPS;
    localparam logic [63:0] SQ_CAP =
        64'(DEFAULT_MAX_WALK_STEPS) * 64'(WALK_LIMIT) * 64'(WALK_LIMIT);
    localparam logic [63:0] P4_CAP = SQ_CAP * 64'(WALK_LIMIT) * 64'(WALK_LIMIT);

    // Result field offsets inside m_tdata
    localparam int SSQ_LSB  = POS_W;
    localparam int SP4_LSB  = SSQ_LSB + SSQ_W;
    localparam int WORD_LSB = SP4_LSB + SP4_W;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int TAIL_CYCLES     = 16;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 135;

    typedef enum logic {
        RX_FREE,
        RX_CHOPPY
    } rx_mode_t;

    typedef struct {
        logic [POS_W-1:0]  position;
        logic [SSQ_W-1:0]  sum_squares;
        logic [SP4_W-1:0]  sum_fourth_powers;
        logic [WORD_W-1:0] random_word;
    } walk_result_t;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata   = '0;   // [0] first_step, rest zero
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;          // position, sum_squares, sum_fourth_powers,
                                           // random_word, zero fill
    logic                cfg_we    = 1'b0;
    logic [0:0]          cfg_addr  = CFG_START_POSITION;
    logic [CFG_W-1:0]    cfg_wdata = '0;

    // Walk state as the block should hold it
    logic [WORD_W-1:0]         lcg_state  = SEED_RESET;
    logic signed [START_W-1:0] walk_start = '0;
    int                        walk_pos   = 0;
    logic [63:0]               square_acc = '0;
    logic [63:0]               fourth_acc = '0;

    walk_result_t walk_results_due[$];
    int           mismatch_count = 0;
    int           cycle_count    = 0;

    // Receiver stall control
    rx_mode_t rx_mode      = RX_FREE;
    int       rx_hold_left = 0;
    int       rx_run       = 0;
    logic     rx_open      = 1'b1;

    lcg_random_walk_1d_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Abort a run that hangs
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("lcg_random_walk_1d_top verification failed");
            $finish;
        end
    end

    function automatic logic [63:0] sat_accumulate(input logic [63:0] acc,
                                                   input logic [63:0] add,
                                                   input logic [63:0] cap);
        if (acc >= cap || add >= cap - acc) begin
            return cap;
        end
        return acc + add;
    endfunction

    // Advance the generator and the walker by one step, return the expected result
    function automatic walk_result_t take_walk_step(input logic first);
        walk_result_t res;
        logic [63:0]  product;
        logic [63:0]  mag;
        logic [63:0]  sq;
        if (first) begin
            walk_pos   = walk_start;
            square_acc = '0;
            fourth_acc = '0;
        end
        product   = 64'(lcg_state) * LCG_MUL + LCG_INC;
        lcg_state = WORD_W'(product % LCG_MOD);
        if (!lcg_state[0]) begin
            if (walk_pos < WALK_LIMIT) begin
                walk_pos++;
            end
        end else if (walk_pos > -WALK_LIMIT) begin
            walk_pos--;
        end
        mag        = 64'(walk_pos < 0 ? -walk_pos : walk_pos);
        sq         = mag * mag;
        square_acc = sat_accumulate(square_acc, sq, SQ_CAP);
        fourth_acc = sat_accumulate(fourth_acc, sq * sq, P4_CAP);
        res.position          = POS_W'(walk_pos);
        res.sum_squares       = SSQ_W'(square_acc);
        res.sum_fourth_powers = SP4_W'(fourth_acc);
        res.random_word       = lcg_state;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("ERROR cycle %0d: %s: got 0x%0h, expected 0x%0h",
                 cycle_count, what, got, want);
        mismatch_count++;
    endtask

    // Offer one step request and hold it until the block takes it
    task automatic send_step(input logic first);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'(first);
        do @(posedge aclk); while (!s_tready);
        walk_results_due.push_back(take_walk_step(first));
    endtask

    task automatic idle_sender(input int cycles);
        repeat (cycles) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
    endtask

    task automatic wait_for_results();
        idle_sender(1);
        while (walk_results_due.size() != 0) @(posedge aclk);
    endtask

    // Write one register while the block is idle and mirror it in the model state
    task automatic write_register(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_START_POSITION: walk_start = value[START_W-1:0];
            CFG_INITIAL_SEED:   lcg_state  = value;
        endcase
    endtask

    // Stall the receiver: a long hold-off first, then its own pattern
    always @(negedge aclk) begin
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_tready <= 1'b0;
        end else if (rx_mode == RX_FREE) begin
            m_tready <= 1'b1;
        end else begin
            if (rx_run == 0) begin
                rx_open = !rx_open;
                rx_run  = rx_open ? $urandom_range(1, 8) : $urandom_range(1, 4);
            end
            rx_run--;
            m_tready <= rx_open;
        end
    end

    // Compare each result request with the oldest one due
    always @(posedge aclk) begin
        walk_result_t due;
        if (aresetn && m_tvalid && m_tready) begin
            if (walk_results_due.size() == 0) begin
                report_mismatch("result with nothing due", 64'(m_tdata[POS_W-1:0]), '0);
            end else begin
                due = walk_results_due.pop_front();
                if (m_tdata[POS_W-1:0] !== due.position)
                    report_mismatch("position", 64'(m_tdata[POS_W-1:0]),
                                    64'(due.position));
                if (m_tdata[SSQ_LSB +: SSQ_W] !== due.sum_squares)
                    report_mismatch("sum_squares", 64'(m_tdata[SSQ_LSB +: SSQ_W]),
                                    64'(due.sum_squares));
                if (m_tdata[SP4_LSB +: SP4_W] !== due.sum_fourth_powers)
                    report_mismatch("sum_fourth_powers", 64'(m_tdata[SP4_LSB +: SP4_W]),
                                    64'(due.sum_fourth_powers));
                if (m_tdata[WORD_LSB +: WORD_W] !== due.random_word)
                    report_mismatch("random_word", 64'(m_tdata[WORD_LSB +: WORD_W]),
                                    64'(due.random_word));
                if (m_tdata[M_DATA_W-1:M_DATA_RAW_W] !== '0)
                    report_mismatch("zero fill", 64'(m_tdata[M_DATA_W-1:M_DATA_RAW_W]),
                                    '0);
            end
        end
    end

    // Walk from the reset seed and start without any first step
    task automatic test_reset_walk();
        repeat (5) send_step(1'b0);
        wait_for_results();
    endtask

    // Start position extremes; a new start applies only at the next first step
    task automatic test_start_position();
        write_register(CFG_START_POSITION, CFG_W'(POS_BASE_LIMIT));
        repeat (2) send_step(1'b0);
        send_step(1'b1);
        repeat (2) send_step(1'b0);
        wait_for_results();
        write_register(CFG_START_POSITION, CFG_W'(-POS_BASE_LIMIT));
        send_step(1'b1);
        repeat (2) send_step(1'b0);
        wait_for_results();
    endtask

    // Seeds at zero, just below, at and above the modulus
    task automatic test_seed_extremes();
        logic [CFG_W-1:0] seeds[4];
        seeds[0] = '0;
        seeds[1] = CFG_W'(LCG_MOD - 64'd1);
        seeds[2] = CFG_W'(LCG_MOD);
        seeds[3] = {CFG_W{1'b1}};
        foreach (seeds[i]) begin
            write_register(CFG_INITIAL_SEED, seeds[i]);
            send_step(1'(i % 2));
            send_step(1'b0);
            wait_for_results();
        end
    endtask

    // Hold the receiver off so the pipeline fills and stalls its input
    task automatic test_back_pressure();
        @(posedge aclk);
        rx_mode      = RX_FREE;
        rx_hold_left = 64;
        repeat (24) send_step(1'($urandom_range(0, 1)));
        wait_for_results();
    endtask

    // Random walks of random length across several register settings
    task automatic test_random_walks();
        int   walk_left;
        int   burst_left;
        int   pick;
        logic gaps_on;
        logic first;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            @(posedge aclk);
            rx_mode = (phase % 2 == 0) ? RX_CHOPPY : RX_FREE;
            gaps_on = (phase % 3 != 2);
            pick    = $urandom_range(0, 3);
            write_register(CFG_START_POSITION,
                           CFG_W'(pick == 0 ? -POS_BASE_LIMIT :
                                  pick == 1 ? POS_BASE_LIMIT :
                                  $urandom_range(0, 2 * POS_BASE_LIMIT) - POS_BASE_LIMIT));
            // Keep the generator running across phases now and then
            if ($urandom_range(0, 3) != 0) begin
                write_register(CFG_INITIAL_SEED, CFG_W'({$urandom, $urandom}));
            end
            walk_left  = 0;
            burst_left = 0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (burst_left == 0) begin
                    if (gaps_on) begin
                        idle_sender($urandom_range(0, 6));
                    end
                    burst_left = $urandom_range(1, 12);
                end
                burst_left--;
                first = (walk_left == 0) || ($urandom_range(0, 31) == 0);
                if (walk_left == 0) begin
                    walk_left = $urandom_range(1, 80);
                end
                walk_left--;
                send_step(first);
            end
            wait_for_results();
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_walk();
        test_start_position();
        test_seed_extremes();
        test_back_pressure();
        test_random_walks();

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (walk_results_due.size() != 0) begin
            report_mismatch("results still due", 64'(walk_results_due.size()), '0);
        end
        if (mismatch_count == 0) begin
            $display("lcg_random_walk_1d_top verification clean");
        end else begin
            $display("lcg_random_walk_1d_top verification failed");
        end
        $finish;
    end

endmodule
